[rtl/clpw_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clpw_pkg
// Shared types and constants for the clipped line pixel walker.
// ----------------------------------------------------------------------------
package clpw_pkg;

	localparam int MAX_DIM      = 64;
	localparam int COORD_BITS   = 12;
	localparam int COLOR_BITS   = 32;
	localparam int DIM_BITS     = 7;
	localparam int PIX_BITS     = 6;
	localparam int CFG_IDX_BITS = 2;

	localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = CFG_IDX_BITS'(1);

	typedef struct packed {
		logic signed [COORD_BITS-1:0] start_x;
		logic signed [COORD_BITS-1:0] start_y;
		logic signed [COORD_BITS-1:0] end_x;
		logic signed [COORD_BITS-1:0] end_y;
		logic        [COLOR_BITS-1:0] line_color;
	} line_cmd_t;

	typedef struct packed {
		logic [PIX_BITS-1:0]   pixel_x;
		logic [PIX_BITS-1:0]   pixel_y;
		logic [COLOR_BITS-1:0] pixel_color;
		logic                  pixel_valid;
		logic                  last_pixel;
	} pixel_t;

endpackage : clpw_pkg
`default_nettype wire

[rtl/clipped_line_pixel_walker_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clipped_line_pixel_walker_unit
// Rejects off-screen lines, then walks the major axis one step per cycle (if no
// output stall) with an error score, emits each on-screen pixel, last flagged.
// ----------------------------------------------------------------------------
// Order: a setup state after the transfer, then the major-axis walk (major =
// |delta| + 1 steps, up to 4096), then a flush state; a pixel leaves one
// on-screen step after it is found, as the walk needs to know if it is last.
// Flow: one line at a time; the next line is taken after the flush. A rejected
// line skips the walk, which ends early if it leaves the screen after a pixel;
// walk and flush hold on stalls; a line with no pixel ends in an empty marker.
// Reset: screen_width and screen_height return to 64, the walker goes idle.
module clipped_line_pixel_walker_unit
	import clpw_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire line_cmd_t               in_data,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output pixel_t                       out_data,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [DIM_BITS-1:0]     cfg_data
);

	localparam int POS_BITS   = COORD_BITS + 1;
	localparam int LEN_BITS   = COORD_BITS + 1;
	localparam int SCORE_BITS = COORD_BITS + 2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_WALK,
		ST_FLUSH
	} state_t;

	state_t state_q;

	logic [DIM_BITS-1:0] scr_w_q, scr_h_q;

	logic signed [POS_BITS-1:0]   x_q, y_q, x1_q, y1_q, ys_q;
	logic [COLOR_BITS-1:0]        color_q;
	logic                         xmajor_q;
	logic [LEN_BITS-1:0]          major_q, minor_q, cnt_q;
	logic signed [SCORE_BITS-1:0] score_q;
	logic                         pend_q;
	logic [PIX_BITS-1:0]          pend_x_q, pend_y_q;

	logic   out_valid_q;
	pixel_t out_q;

	// effective screen size
	logic [DIM_BITS-1:0] w_eff, h_eff;
	assign w_eff = (scr_w_q > DIM_BITS'(MAX_DIM)) ? DIM_BITS'(MAX_DIM) : scr_w_q;
	assign h_eff = (scr_h_q > DIM_BITS'(MAX_DIM)) ? DIM_BITS'(MAX_DIM) : scr_h_q;

	logic signed [POS_BITS-1:0] w_s, h_s;
	assign w_s = signed'({{(POS_BITS-DIM_BITS){1'b0}}, w_eff});
	assign h_s = signed'({{(POS_BITS-DIM_BITS){1'b0}}, h_eff});

	// input swap so that x rises
	logic swap;
	assign swap = in_data.start_x > in_data.end_x;

	// setup arithmetic
	logic signed [POS_BITS-1:0] dy, ymin, ymax;
	logic [LEN_BITS-1:0]        xd, yd, ady;
	logic                       reject, xm;
	assign dy     = y1_q - y_q;
	assign ady    = dy[POS_BITS-1] ? LEN_BITS'(-dy) : LEN_BITS'(dy);
	assign xd     = LEN_BITS'(x1_q - x_q) + LEN_BITS'(1);
	assign yd     = ady + LEN_BITS'(1);
	assign ymin   = dy[POS_BITS-1] ? y1_q : y_q;
	assign ymax   = dy[POS_BITS-1] ? y_q : y1_q;
	assign reject = (x_q >= w_s) || (x1_q < 0) || (ymin >= h_s) || (ymax < 0);
	assign xm     = xd >= yd;

	// walk step
	logic                         on_scr, can_load, out_load;
	logic signed [SCORE_BITS-1:0] score_sub;
	logic                         minor_step;
	assign on_scr     = (x_q >= 0) && (x_q < w_s) && (y_q >= 0) && (y_q < h_s);
	assign can_load   = !out_valid_q || out_ready;
	assign score_sub  = score_q - signed'(SCORE_BITS'(minor_q));
	assign minor_step = score_sub <= 0;
	assign out_load   = ((state_q == ST_WALK) && on_scr && pend_q && can_load) ||
	                    ((state_q == ST_FLUSH) && can_load);

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr_w_q <= DIM_BITS'(MAX_DIM);
			scr_h_q <= DIM_BITS'(MAX_DIM);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SCREEN_WIDTH:  scr_w_q <= cfg_data;
				REG_SCREEN_HEIGHT: scr_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						x_q     <= POS_BITS'(swap ? in_data.end_x : in_data.start_x);
						y_q     <= POS_BITS'(swap ? in_data.end_y : in_data.start_y);
						x1_q    <= POS_BITS'(swap ? in_data.start_x : in_data.end_x);
						y1_q    <= POS_BITS'(swap ? in_data.start_y : in_data.end_y);
						color_q <= in_data.line_color;
						pend_q  <= 1'b0;
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					xmajor_q <= xm;
					major_q  <= xm ? xd : yd;
					minor_q  <= xm ? yd : xd;
					cnt_q    <= xm ? xd : yd;
					score_q  <= signed'(SCORE_BITS'(xm ? xd : yd));
					ys_q     <= (dy == 0) ? POS_BITS'(0) :
					            (dy[POS_BITS-1] ? -POS_BITS'(1) : POS_BITS'(1));
					state_q  <= reject ? ST_FLUSH : ST_WALK;
				end
				ST_WALK: begin
					if (!on_scr && pend_q) begin
						state_q <= ST_FLUSH;
					end else if (!(on_scr && pend_q && !can_load)) begin
						if (on_scr) begin
							if (pend_q) begin
								out_q <= '{pixel_x: pend_x_q, pixel_y: pend_y_q,
								           pixel_color: color_q, pixel_valid: 1'b1,
								           last_pixel: 1'b0};
							end
							pend_q   <= 1'b1;
							pend_x_q <= x_q[PIX_BITS-1:0];
							pend_y_q <= y_q[PIX_BITS-1:0];
						end
						score_q <= minor_step ? score_sub + signed'(SCORE_BITS'(major_q))
						                      : score_sub;
						if (xmajor_q) begin
							x_q <= x_q + POS_BITS'(1);
							if (minor_step)
								y_q <= y_q + ys_q;
						end else begin
							y_q <= y_q + ys_q;
							if (minor_step)
								x_q <= x_q + POS_BITS'(1);
						end
						cnt_q <= cnt_q - LEN_BITS'(1);
						if (cnt_q == LEN_BITS'(1))
							state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (can_load) begin
						if (pend_q)
							out_q <= '{pixel_x: pend_x_q, pixel_y: pend_y_q,
							           pixel_color: color_q, pixel_valid: 1'b1,
							           last_pixel: 1'b1};
						else
							out_q <= '{pixel_x: '0, pixel_y: '0, pixel_color: '0,
							           pixel_valid: 1'b0, last_pixel: 1'b1};
						pend_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule : clipped_line_pixel_walker_unit
`default_nettype wire

[sim/clipped_line_pixel_walker_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clipped_line_pixel_walker_unit_tb
// Drives line commands through the walker under several screen sizes. Each
// accepted command is traced in software into its run of pixels, and the pixel
// stream is compared in order, field by field. The sender idles in bursts and
// the pixel receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module clipped_line_pixel_walker_unit_tb
	import clpw_pkg::*;
;

	localparam int QUIET_LIMIT  = 20000;
	localparam int SETTLE       = 8;
	localparam int DRAIN_CYCLES = 20;
	localparam int NUM_PHASES   = 8;
	localparam int PHASE_LINES  = 13;
	localparam int REPORT_CAP   = 30;

	// indexes the block does not decode
	localparam logic [CFG_IDX_BITS-1:0] REG_UNMAPPED_A = CFG_IDX_BITS'(2);
	localparam logic [CFG_IDX_BITS-1:0] REG_UNMAPPED_B = CFG_IDX_BITS'(3);

	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_CADENCE} rx_mode_e;

	class line_pixel_tracker;
		int unsigned scr_w;
		int unsigned scr_h;
		pixel_t      due_pixels[$];
		int unsigned errors;
		int unsigned lines_noted;
		int unsigned pixels_seen;
		int unsigned empties_seen;

		function new();
			scr_w = MAX_DIM;
			scr_h = MAX_DIM;
		endfunction

		function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [DIM_BITS-1:0] val);
			if (idx == REG_SCREEN_WIDTH)
				scr_w = val;
			else if (idx == REG_SCREEN_HEIGHT)
				scr_h = val;
		endfunction

		// trace the clipped walk and queue every pixel it should emit
		function void note_line(line_cmd_t cmd);
			int x0, y0, x1, y1, tmp, w, h, ymin, ymax;
			int xd, yd, ys, major, minor, score, x, y, n;
			bit xmajor;
			pixel_t px;
			x0 = $signed(cmd.start_x);
			y0 = $signed(cmd.start_y);
			x1 = $signed(cmd.end_x);
			y1 = $signed(cmd.end_y);
			w = (scr_w > MAX_DIM) ? MAX_DIM : int'(scr_w);
			h = (scr_h > MAX_DIM) ? MAX_DIM : int'(scr_h);
			n = 0;
			if (x0 > x1) begin
				tmp = x0; x0 = x1; x1 = tmp;
				tmp = y0; y0 = y1; y1 = tmp;
			end
			ymin = (y0 < y1) ? y0 : y1;
			ymax = (y0 < y1) ? y1 : y0;
			if (!(x0 >= w || x1 < 0 || ymin >= h || ymax < 0)) begin
				xd = x1 - x0 + 1;
				yd = ((y1 >= y0) ? y1 - y0 : y0 - y1) + 1;
				ys = (y1 == y0) ? 0 : ((y1 > y0) ? 1 : -1);
				xmajor = (xd >= yd);
				major = xmajor ? xd : yd;
				minor = xmajor ? yd : xd;
				score = major;
				x = x0;
				y = y0;
				for (int i = 0; i < major; i++) begin
					if (x >= 0 && x < w && y >= 0 && y < h) begin
						if (n >= MAX_DIM)
							break;
						px = '0;
						px.pixel_x = PIX_BITS'(x);
						px.pixel_y = PIX_BITS'(y);
						px.pixel_color = cmd.line_color;
						px.pixel_valid = 1'b1;
						due_pixels.push_back(px);
						n++;
					end else if (n != 0) begin
						break;
					end
					if (xmajor) begin
						x += 1;
						score -= minor;
						if (score <= 0) begin
							score += major;
							y += ys;
						end
					end else begin
						y += ys;
						score -= minor;
						if (score <= 0) begin
							score += major;
							x += 1;
						end
					end
				end
			end
			if (n == 0)
				due_pixels.push_back('0);
			px = due_pixels.pop_back();
			px.last_pixel = 1'b1;
			due_pixels.push_back(px);
			lines_noted++;
		endfunction

		function void flag(string field, logic [63:0] want, logic [63:0] got);
			errors++;
			if (errors <= REPORT_CAP)
				$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
		endfunction

		function void check_pixel(pixel_t got);
			pixel_t want;
			if (got.pixel_valid === 1'b1)
				pixels_seen++;
			else
				empties_seen++;
			if (due_pixels.size() == 0) begin
				errors++;
				$error("pixel transfer with nothing expected: %p", got);
				return;
			end
			want = due_pixels.pop_front();
			if (got.pixel_x !== want.pixel_x)
				flag("pixel_x", want.pixel_x, got.pixel_x);
			if (got.pixel_y !== want.pixel_y)
				flag("pixel_y", want.pixel_y, got.pixel_y);
			if (got.pixel_color !== want.pixel_color)
				flag("pixel_color", want.pixel_color, got.pixel_color);
			if (got.pixel_valid !== want.pixel_valid)
				flag("pixel_valid", want.pixel_valid, got.pixel_valid);
			if (got.last_pixel !== want.last_pixel)
				flag("last_pixel", want.last_pixel, got.last_pixel);
		endfunction

		function int pending();
			return due_pixels.size();
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	line_cmd_t               in_data;
	logic                    out_valid;
	logic                    out_ready;
	pixel_t                  out_data;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [DIM_BITS-1:0]     cfg_data;

	line_pixel_tracker sb;
	int unsigned       burst_left;
	int unsigned       quiet_cycles;
	int unsigned       cfg_writes;

	clipped_line_pixel_walker_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic line_cmd_t mk_line(int x0, int y0, int x1, int y1,
			logic [COLOR_BITS-1:0] color);
		line_cmd_t cmd;
		cmd.start_x = COORD_BITS'(x0);
		cmd.start_y = COORD_BITS'(y0);
		cmd.end_x = COORD_BITS'(x1);
		cmd.end_y = COORD_BITS'(y1);
		cmd.line_color = color;
		return cmd;
	endfunction

	// mostly lines around the visible area, some spanning the whole range
	function automatic line_cmd_t rand_line();
		int wd, ht, kind, far;
		int c[4];
		wd = (sb.scr_w == 0) ? 8 : ((sb.scr_w > MAX_DIM) ? MAX_DIM : int'(sb.scr_w));
		ht = (sb.scr_h == 0) ? 8 : ((sb.scr_h > MAX_DIM) ? MAX_DIM : int'(sb.scr_h));
		kind = $urandom_range(0, 99);
		c[0] = int'($urandom_range(0, wd + 16)) - 8;
		c[1] = int'($urandom_range(0, ht + 16)) - 8;
		c[2] = int'($urandom_range(0, wd + 16)) - 8;
		c[3] = int'($urandom_range(0, ht + 16)) - 8;
		if (kind >= 85) begin
			foreach (c[i])
				c[i] = int'($urandom_range(0, 4095)) - 2048;
		end else if (kind >= 65) begin
			far = 2 * int'($urandom_range(0, 1));
			c[far] = int'($urandom_range(0, 4095)) - 2048;
			if ($urandom_range(0, 1))
				c[far + 1] = int'($urandom_range(0, 4095)) - 2048;
		end
		return mk_line(c[0], c[1], c[2], c[3], $urandom);
	endfunction

	task automatic send_line(input line_cmd_t cmd);
		in_data <= cmd;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		sb.note_line(cmd);
		@(negedge clk);
		if (burst_left > 1) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 20)) @(negedge clk);
			burst_left = $urandom_range(1, 16);
		end
	endtask

	task automatic finish_phase();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic program_reg(input logic [CFG_IDX_BITS-1:0] idx, input int unsigned val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= DIM_BITS'(val);
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, DIM_BITS'(val));
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// pixel receiver back-pressure
	initial begin
		rx_mode_e    mode;
		int unsigned span;
		int unsigned tick;
		out_ready = 1'b0;
		tick = 0;
		forever begin
			mode = rx_mode_e'($urandom_range(0, 3));
			span = $urandom_range(16, 200);
			repeat (span) begin
				@(negedge clk);
				tick++;
				case (mode)
					RX_OPEN:    out_ready <= 1'b1;
					RX_COIN:    out_ready <= 1'($urandom_range(0, 1));
					RX_SPARSE:  out_ready <= ($urandom_range(0, 7) == 0);
					RX_CADENCE: out_ready <= ((tick % 5) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_pixel(out_data);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", quiet_cycles);
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		line_cmd_t   directed[$];
		int unsigned w;
		int unsigned h;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_SCREEN_WIDTH;
		cfg_data = '0;
		cfg_writes = 0;
		sb = new();
		burst_left = $urandom_range(1, 16);

		directed.push_back(mk_line(0, 0, 63, 0, 32'hFFFF_FFFF));
		directed.push_back(mk_line(5, 63, 5, 0, 32'h0000_0000));
		directed.push_back(mk_line(10, 10, 10, 10, 32'h1234_5678));
		directed.push_back(mk_line(40, 30, 3, 12, 32'hDEAD_BEEF));
		directed.push_back(mk_line(2047, 2047, -2048, -2048, 32'h8000_0001));
		directed.push_back(mk_line(-2048, 5, -100, 5, 32'h0F0F_0F0F));
		directed.push_back(mk_line(64, 0, 2047, 63, 32'hF0F0_F0F0));
		directed.push_back(mk_line(0, 64, 63, 2047, 32'h5555_5555));
		directed.push_back(mk_line(0, -2048, 63, -1, 32'hAAAA_AAAA));
		directed.push_back(mk_line(-10, 5, 5, -10, 32'h0000_0001));
		directed.push_back(mk_line(-30, -3, 90, 70, 32'hCAFE_F00D));
		directed.push_back(mk_line(3, 60, 20, -2, 32'h7FFF_FFFF));
		directed.push_back(mk_line(0, 0, 1, 63, 32'h0000_FFFF));
		directed.push_back(mk_line(-2048, 2047, 2047, -2048, 32'hFFFF_0000));
		directed.push_back(mk_line(63, 63, 63, 63, 32'h00FF_00FF));
		directed.push_back(mk_line(0, 0, 64, 64, 32'hFF00_FF00));
		directed.push_back(mk_line(-1, -1, 62, 62, 32'h3C3C_3C3C));
		directed.push_back(mk_line(20, 7, 50, 9, 32'hA5A5_5A5A));
		directed.push_back(mk_line(1000, 30, -1000, 31, 32'h0BAD_CAFE));
		directed.push_back(mk_line(30, -2048, 31, 2047, 32'h1111_2222));

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		foreach (directed[i])
			send_line(directed[i]);
		finish_phase();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: begin w = 127; h = 127; end
				1: begin w = 1;   h = 1;   end
				2: begin w = 0;   h = 64;  end
				3: begin w = 64;  h = 0;   end
				4: begin w = 64;  h = 64;  end
				default: begin
					w = $urandom_range(0, 9) == 0 ? $urandom_range(65, 127) : $urandom_range(1, 64);
					h = $urandom_range(0, 9) == 0 ? $urandom_range(65, 127) : $urandom_range(1, 64);
				end
			endcase
			program_reg(REG_SCREEN_WIDTH, w);
			program_reg(REG_SCREEN_HEIGHT, h);
			if (ph == 0) begin
				program_reg(REG_UNMAPPED_A, 0);
				program_reg(REG_UNMAPPED_B, 7'h55);
			end
			repeat (PHASE_LINES)
				send_line(rand_line());
			finish_phase();
		end

		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run: %0d line commands, %0d pixels drawn, %0d empty markers",
			sb.lines_noted, sb.pixels_seen, sb.empties_seen);
		$display("Screen register writes: %0d, sizes from zero and one up to oversized",
			cfg_writes);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[sim.f]
rtl/clpw_pkg.sv
rtl/clipped_line_pixel_walker_unit.sv
sim/clipped_line_pixel_walker_unit_tb.sv
